FILE: rtl/ptl_pkg.sv
// shared types, constants and the phoneme-to-shape map of the timeline lookup
`timescale 1ns / 1ps

package ptl_pkg;

  localparam int MaxEntries = 256;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = IdxW + 1;
  localparam int FrameW     = 16;
  localparam int ShapeW     = 4;
  localparam int PhonemeW   = 16;

  typedef enum logic [1:0] {
    KindClear  = 2'd0,
    KindAppend = 2'd1,
    KindQuery  = 2'd2
  } ptl_kind_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [FrameW-1:0]   start_frame;
    logic [PhonemeW-1:0] phoneme;
    logic [FrameW-1:0]   position;
  } ptl_in_t;

  typedef struct packed {
    logic [ShapeW-1:0] shape;
    logic              found;
    logic              unknown_phoneme;
    logic              table_full;
  } ptl_out_t;

  // query item walking down the row of cells
  typedef struct packed {
    logic              act;
    logic              found;
    logic [ShapeW-1:0] shape;
  } ptl_tok_t;

  // entry write broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [FrameW-1:0] frame;
    logic [ShapeW-1:0] shape;
  } ptl_wr_t;

  typedef struct packed {
    logic              unknown;
    logic [ShapeW-1:0] shape;
  } ptl_map_t;

  function automatic ptl_map_t ptl_map_phoneme(logic [PhonemeW-1:0] code);
    ptl_map_t m;
    m.unknown = 1'b0;
    m.shape   = 4'd1;
    unique case (code)
      16'h005F: m.shape = 4'd0;
      16'h0251: m.shape = 4'd1;
      16'h0061: m.shape = 4'd1;
      16'h00E6: m.shape = 4'd1;
      16'h028C: m.shape = 4'd8;
      16'h0254: m.shape = 4'd1;
      16'h0259: m.shape = 4'd1;
      16'h0062: m.shape = 4'd6;
      16'h02A7: m.shape = 4'd2;
      16'h0064: m.shape = 4'd2;
      16'h00F0: m.shape = 4'd5;
      16'h025B: m.shape = 4'd8;
      16'h0268: m.shape = 4'd8;
      16'h025A: m.shape = 4'd9;
      16'h025D: m.shape = 4'd9;
      16'h0065: m.shape = 4'd1;
      16'h0066: m.shape = 4'd4;
      16'h0067: m.shape = 4'd8;
      16'h0261: m.shape = 4'd8;
      16'h0068: m.shape = 4'd8;
      16'h026A: m.shape = 4'd8;
      16'h0069: m.shape = 4'd3;
      16'h02A4: m.shape = 4'd2;
      16'h006B: m.shape = 4'd2;
      16'h006C: m.shape = 4'd5;
      16'h026B: m.shape = 4'd5;
      16'h006D: m.shape = 4'd6;
      16'h006E: m.shape = 4'd8;
      16'h014B: m.shape = 4'd8;
      16'h006F: m.shape = 4'd7;
      16'h0070: m.shape = 4'd6;
      16'h0072: m.shape = 4'd2;
      16'h027B: m.shape = 4'd2;
      16'h0279: m.shape = 4'd2;
      16'h0073: m.shape = 4'd2;
      16'h0283: m.shape = 4'd2;
      16'h0074: m.shape = 4'd2;
      16'h027E: m.shape = 4'd2;
      16'h03B8: m.shape = 4'd5;
      16'h028A: m.shape = 4'd9;
      16'h0075: m.shape = 4'd9;
      16'h0076: m.shape = 4'd4;
      16'h0077: m.shape = 4'd9;
      16'h006A: m.shape = 4'd8;
      16'h007A: m.shape = 4'd2;
      16'h0292: m.shape = 4'd2;
      16'h002E: m.shape = 4'd2;
      16'h0000: m.shape = 4'd0;
      default: begin
        m.unknown = 1'b1;
        m.shape   = 4'd1;
      end
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/ptl_cell.sv
// one timeline cell: holds one entry and checks the passing query item
`timescale 1ns / 1ps

module ptl_cell
  import ptl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IdxW-1:0]   idx_i,
  input  logic [CntW-1:0]   count_i,
  input  ptl_wr_t           wr_i,
  input  logic [FrameW-1:0] pos_i,
  input  logic [FrameW-1:0] nxt_frame_i,
  input  ptl_tok_t          tok_i,
  output logic [FrameW-1:0] frame_o,
  output ptl_tok_t          tok_o
);

  logic [FrameW-1:0] frame_q;
  logic [ShapeW-1:0] shape_q;
  ptl_tok_t          tok_q, tok_d;
  logic              in_range, last, match;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == idx_i)) begin
      frame_q <= wr_i.frame;
      shape_q <= wr_i.shape;
    end
  end

  assign in_range = CntW'(idx_i) < count_i;
  assign last     = (CntW'(idx_i) + CntW'(1)) == count_i;
  assign match    = in_range && (pos_i >= frame_q) && (last || (pos_i < nxt_frame_i));

  always_comb begin
    tok_d = tok_i;
    // first matching entry wins, later cells only pass the item on
    if (tok_i.act && !tok_i.found && match) begin
      tok_d.found = 1'b1;
      tok_d.shape = shape_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign frame_o = frame_q;
  assign tok_o   = tok_q;

endmodule

FILE: rtl/phoneme_timeline_lookup_top.sv
// top level of the phoneme timeline lookup: control, entry count and the row of cells
`timescale 1ns / 1ps

// Timeline of up to 256 entries (start frame, mouth shape) kept in load order,
// one entry per cell in a row of 256 cells. One item is worked on at a time:
// in_stall_o rises at acceptance and falls when the result moves into the
// output register. Clear, append and unused-kind items go through the result
// register (res_q, done_q) into the output register. A query item walks the
// row one cell per clock, through the launch register and every cell of the
// row whatever the number of entries, then through the result register into
// the output register. A result held in the output register by out_stall_i
// keeps the next result from moving in, and with it the next acceptance.

module phoneme_timeline_lookup_top
  import ptl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ptl_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ptl_out_t out_data_o
);

  logic              busy_q, launch_q, done_q, out_valid_q;
  logic [CntW-1:0]   count_q;
  logic [FrameW-1:0] pos_q;
  ptl_out_t          res_q, out_q;

  logic              accept, is_full, out_free;
  ptl_map_t          map;
  ptl_wr_t           wr;
  ptl_tok_t          tok [MaxEntries+1];
  logic [FrameW-1:0] frames [MaxEntries+1];

  assign accept   = in_valid_i && !busy_q;
  assign is_full  = count_q >= CntW'(MaxEntries);
  assign out_free = !out_valid_q || !out_stall_i;
  assign map      = ptl_map_phoneme(in_data_i.phoneme);

  always_comb begin
    wr.en    = accept && (in_data_i.kind == KindAppend) && !is_full;
    wr.idx   = count_q[IdxW-1:0];
    wr.frame = in_data_i.start_frame;
    wr.shape = map.shape;
  end

  assign tok[0]              = '{act: launch_q, found: 1'b0, shape: '0};
  assign frames[MaxEntries]  = '0;

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    ptl_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IdxW'(g)),
      .count_i     (count_q),
      .wr_i        (wr),
      .pos_i       (pos_q),
      .nxt_frame_i (frames[g+1]),
      .tok_i       (tok[g]),
      .frame_o     (frames[g]),
      .tok_o       (tok[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      launch_q    <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      pos_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      launch_q <= accept && (in_data_i.kind == KindQuery);

      if (accept) begin
        busy_q <= 1'b1;
        pos_q  <= in_data_i.position;
        unique case (in_data_i.kind)
          KindClear: begin
            count_q <= '0;
            res_q   <= '0;
            done_q  <= 1'b1;
          end
          KindAppend: begin
            res_q <= '{shape: map.shape, found: 1'b0,
                       unknown_phoneme: map.unknown, table_full: is_full};
            if (!is_full) begin
              count_q <= count_q + CntW'(1);
            end
            done_q <= 1'b1;
          end
          KindQuery: begin
            // result comes from the far end of the row
          end
          default: begin
            res_q  <= '0;
            done_q <= 1'b1;
          end
        endcase
      end

      if (tok[MaxEntries].act) begin
        res_q  <= '{shape: tok[MaxEntries].shape, found: tok[MaxEntries].found,
                    unknown_phoneme: 1'b0, table_full: 1'b0};
        done_q <= 1'b1;
      end

      if (done_q && out_free) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
        done_q      <= 1'b0;
        busy_q      <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sim/tb_phoneme_timeline_lookup_top.sv
// testbench of the phoneme timeline lookup: timeline sessions checked against a predictor
`timescale 1ns / 1ps

module tb_phoneme_timeline_lookup_top
  import ptl_pkg::*;
();

  localparam logic [1:0] KindSpare = 2'd3;
  localparam int PhCount       = 48;
  localparam int ItemTarget    = 1250;
  localparam int HoldOffAt     = 150;
  localparam int HoldOffCycles = 600;
  localparam int DrainCycles   = 300;
  localparam int MaxReported   = 10;

  localparam logic [PhonemeW-1:0] PhCodes [PhCount] = '{
    16'h005F, 16'h0251, 16'h0061, 16'h00E6, 16'h028C, 16'h0254, 16'h0259, 16'h0062,
    16'h02A7, 16'h0064, 16'h00F0, 16'h025B, 16'h0268, 16'h025A, 16'h025D, 16'h0065,
    16'h0066, 16'h0067, 16'h0261, 16'h0068, 16'h026A, 16'h0069, 16'h02A4, 16'h006B,
    16'h006C, 16'h026B, 16'h006D, 16'h006E, 16'h014B, 16'h006F, 16'h0070, 16'h0072,
    16'h027B, 16'h0279, 16'h0073, 16'h0283, 16'h0074, 16'h027E, 16'h03B8, 16'h028A,
    16'h0075, 16'h0076, 16'h0077, 16'h006A, 16'h007A, 16'h0292, 16'h002E, 16'h0000
  };
  localparam logic [ShapeW-1:0] PhShapes [PhCount] = '{
    4'd0, 4'd1, 4'd1, 4'd1, 4'd8, 4'd1, 4'd1, 4'd6,
    4'd2, 4'd2, 4'd5, 4'd8, 4'd8, 4'd9, 4'd9, 4'd1,
    4'd4, 4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd2, 4'd2,
    4'd5, 4'd5, 4'd6, 4'd8, 4'd8, 4'd7, 4'd6, 4'd2,
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd5, 4'd9,
    4'd9, 4'd4, 4'd9, 4'd8, 4'd2, 4'd2, 4'd2, 4'd0
  };

  class timeline_scoreboard;
    logic [FrameW-1:0] frame_tbl [MaxEntries];
    logic [ShapeW-1:0] shape_tbl [MaxEntries];
    int held;
    ptl_out_t due_results[$];
    int errors, reported, checked;
    int clears, appends, queries, hits, drops, unknowns, spares;

    function new();
      held = 0;
      errors = 0;
      reported = 0;
      checked = 0;
      clears = 0;
      appends = 0;
      queries = 0;
      hits = 0;
      drops = 0;
      unknowns = 0;
      spares = 0;
    endfunction

    // works out the result of one accepted item and updates the timeline copy
    function void note_item(ptl_in_t it);
      ptl_out_t r;
      logic [ShapeW-1:0] s;
      logic unk;
      bit is_last, upper_ok;
      r = '0;
      case (it.kind)
        KindClear: begin
          held = 0;
          clears++;
        end
        KindAppend: begin
          unk = 1'b1;
          s = 4'd1;
          for (int k = 0; k < PhCount; k++) begin
            if (PhCodes[k] == it.phoneme) begin
              unk = 1'b0;
              s = PhShapes[k];
              break;
            end
          end
          r.shape = s;
          r.unknown_phoneme = unk;
          if (held < MaxEntries) begin
            frame_tbl[held] = it.start_frame;
            shape_tbl[held] = s;
            held++;
          end else begin
            r.table_full = 1'b1;
            drops++;
          end
          appends++;
          if (unk) unknowns++;
        end
        KindQuery: begin
          queries++;
          for (int i = 0; i < held; i++) begin
            // last entry has no upper bound
            is_last = (i + 1 >= held);
            upper_ok = is_last ? 1'b1 : (it.position < frame_tbl[i+1]);
            if (it.position >= frame_tbl[i] && upper_ok) begin
              r.shape = shape_tbl[i];
              r.found = 1'b1;
              hits++;
              break;
            end
          end
        end
        default: begin
          spares++;
        end
      endcase
      due_results.push_back(r);
    endfunction

    function void check_result(ptl_out_t got);
      ptl_out_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (reported < MaxReported) begin
          $display("unexpected result: shape %0d found %0b unknown %0b full %0b",
                   got.shape, got.found, got.unknown_phoneme, got.table_full);
        end
        reported++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got.shape !== want.shape || got.found !== want.found ||
          got.unknown_phoneme !== want.unknown_phoneme || got.table_full !== want.table_full) begin
        errors++;
        if (reported < MaxReported) begin
          $display("result %0d mismatch: expected shape %0d found %0b unknown %0b full %0b",
                   checked, want.shape, want.found, want.unknown_phoneme, want.table_full);
          $display("  actual: shape %0d found %0b unknown %0b full %0b",
                   got.shape, got.found, got.unknown_phoneme, got.table_full);
        end
        reported++;
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  ptl_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  ptl_out_t out_data_o;

  timeline_scoreboard sb = new();

  int items_sent = 0;
  int results_taken = 0;
  int send_calm = 0;
  int recv_calm = 0;
  bit held_off = 1'b0;
  logic [FrameW-1:0] session_frames[$];

  phoneme_timeline_lookup_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // idle cycles before the next item, with occasional runs of back-to-back items
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // all fields random, kind left at the unused code
  function automatic ptl_in_t scramble();
    ptl_in_t it;
    it.kind        = KindSpare;
    it.start_frame = FrameW'($urandom);
    it.phoneme     = PhonemeW'($urandom);
    it.position    = FrameW'($urandom);
    return it;
  endfunction

  function automatic logic [PhonemeW-1:0] pick_phoneme();
    if ($urandom_range(0, 6) == 0) return PhonemeW'($urandom);
    return PhCodes[$urandom_range(0, PhCount - 1)];
  endfunction

  // mostly positions on or next to a frame of the session
  function automatic logic [FrameW-1:0] pick_position();
    int sel;
    int base;
    sel = $urandom_range(0, 9);
    if (session_frames.size() == 0 || sel == 0) return FrameW'($urandom);
    if (sel == 1) return '0;
    if (sel == 2) return '1;
    base = int'(session_frames[$urandom_range(0, session_frames.size() - 1)]);
    base = base + $urandom_range(0, 2) - 1;
    return base[FrameW-1:0];
  endfunction

  task automatic offer(ptl_in_t it);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic clear_table();
    ptl_in_t it;
    it = scramble();
    it.kind = KindClear;
    offer(it);
  endtask

  task automatic append_entry(logic [FrameW-1:0] frame, logic [PhonemeW-1:0] code);
    ptl_in_t it;
    it = scramble();
    it.kind = KindAppend;
    it.start_frame = frame;
    it.phoneme = code;
    offer(it);
  endtask

  task automatic query_at(logic [FrameW-1:0] pos);
    ptl_in_t it;
    it = scramble();
    it.kind = KindQuery;
    it.position = pos;
    offer(it);
  endtask

  initial begin : stimulus
    int sess;
    int n_ent;
    int fv;
    bit ordered;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    query_at(16'h0000);
    offer(scramble());
    append_entry(16'h0000, 16'h0000);
    append_entry(16'd100, 16'h0069);
    // same frame twice, second one unknown
    append_entry(16'd100, 16'hFFFF);
    // frame going backwards, so the pair before it never matches
    append_entry(16'd50, 16'h006F);
    append_entry(16'hFFFF, 16'h025A);
    query_at(16'd0);
    query_at(16'd49);
    query_at(16'd99);
    query_at(16'd100);
    query_at(16'd50);
    query_at(16'hFFFE);
    query_at(16'hFFFF);
    clear_table();
    query_at(16'hFFFF);
    append_entry(16'h8000, 16'h8000);
    append_entry(16'h1234, 16'h005F);
    query_at(16'h1000);
    query_at(16'h7FFF);
    query_at(16'hFFFF);

    sess = 0;
    while (items_sent < ItemTarget) begin
      if (sess == 0 || $urandom_range(0, 4) != 0) begin
        clear_table();
        session_frames.delete();
      end
      // first session always runs past a full table
      if (sess == 0) n_ent = 260;
      else if ($urandom_range(0, 9) == 0) n_ent = $urandom_range(250, 262);
      else n_ent = $urandom_range(0, 12);
      ordered = ($urandom_range(0, 3) != 0);
      fv = $urandom_range(0, 3000);
      for (int e = 0; e < n_ent; e++) begin
        if (ordered) begin
          fv = fv + $urandom_range(0, (n_ent > 100) ? 250 : 4000);
          if (fv > 65535) fv = 65535;
        end else begin
          fv = $urandom_range(0, 65535);
        end
        append_entry(fv[FrameW-1:0], pick_phoneme());
        session_frames.push_back(fv[FrameW-1:0]);
        if ($urandom_range(0, 5) == 0) query_at(pick_position());
        if ($urandom_range(0, 40) == 0) offer(scramble());
      end
      repeat ($urandom_range(2, 8)) query_at(pick_position());
      sess++;
    end
    in_valid_i <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("ran %0d items in %0d sessions: %0d appends (%0d unknown, %0d dropped as full),",
             items_sent, sess, sb.appends, sb.unknowns, sb.drops);
    $display("%0d queries (%0d matched), %0d clears, %0d unused kinds; %0d mismatches",
             sb.queries, sb.hits, sb.clears, sb.spares, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_phoneme_timeline_lookup_top OK");
    end else begin
      $display("tb_phoneme_timeline_lookup_top NOT OK");
    end
    $finish;
  end

  initial begin : result_side
    int wait_cycles;
    @(posedge rst_ni);
    forever begin
      // one long hold-off so the block backs up and stalls its input
      if (results_taken == HoldOffAt && !held_off) begin
        wait_cycles = HoldOffCycles;
        held_off = 1'b1;
      end else begin
        wait_cycles = draw_wait(recv_calm);
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
      results_taken++;
    end
  end

  initial begin : watchdog
    #(40_000_000);
    $display("tb_phoneme_timeline_lookup_top NOT OK");
    $finish;
  end

endmodule
